@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file wti_checker.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high.
`define WTI_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, also checked during reset.
`define WTI_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/wti_pkg.sv @@
// Shared types and constants of the waypoint trajectory interpolator.
// No dependencies.
package wti_pkg;

  localparam int MaxPoints = 64;
  localparam int Joints    = 7;
  localparam int PtW       = 6;   // waypoint index
  localparam int ElemW     = 9;   // waypoint x joint element address
  localparam int DivW      = 56;  // dividend width of the shared divider
  localparam int DsrW      = 32;  // divisor width

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_CANCEL = 2'd3;

  localparam logic [1:0] STAT_RUN = 2'd0;
  localparam logic [1:0] STAT_FIN = 2'd1;
  localparam logic [1:0] STAT_REJ = 2'd2;

  localparam logic [1:0] REG_SLOT_MAP = 2'd0;
  localparam logic [1:0] REG_FLIP     = 2'd1;
  localparam logic [1:0] REG_JOINTS   = 2'd2;

  localparam logic [3:0]  SLOT_NONE  = 4'd15;
  localparam logic [24:0] US_PER_SEC = 25'd1000000;

  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        time_us;
    logic [5:0]         point_index;
    logic [2:0]         joint;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic [6:0]         point_count;
  } wti_in_t;

  typedef struct packed {
    logic [3:0]         slot;
    logic signed [31:0] joint_position;
    logic signed [31:0] joint_velocity;
    logic [1:0]         status;
    logic               last;
  } wti_out_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } wti_div_ctl_t;

endpackage

@@ rtl/wti_if.sv @@
// Valid/ready channel interfaces for the interpolator's input and result words.
// Depends on wti_pkg.
interface wti_in_if import wti_pkg::*; ();
  logic    valid;
  logic    ready;
  wti_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wti_out_if import wti_pkg::*; ();
  logic     valid;
  logic     ready;
  wti_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/waypoint_trajectory_interpolator.sv @@
// Channel   | dir | payload   | note
// in_ch     | in  | wti_in_t  | load/start/tick/cancel word
// out_ch    | out | wti_out_t | one word per mapped joint, or start reject
// cfg_*     | in  | 28 bits   | slot map, flip mask, joints in use
// A rejected start emits a reject word. A tick first checks the end of the trajectory;
// past the end it emits the last waypoint for each mapped joint. Otherwise it walks the
// segments, does the ratio divide and, per mapped joint, a velocity divide in the shared
// 56-step divider; a zero-length segment skips both divides.
// Reset is synchronous and clears control state, not the waypoint tables. A stalled result
// word holds the sequencer; input is taken only when the sequencer is idle.
module waypoint_trajectory_interpolator import wti_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [27:0] cfg_data,
  wti_in_if.sink      in_ch,
  wti_out_if.source   out_ch
);
  localparam logic [4:0] S_IDLE = 5'd0, S_LASTT = 5'd1, S_LASTC = 5'd2, S_WALK = 5'd3,
    S_WALKC = 5'd4, S_T0 = 5'd5, S_T0C = 5'd6, S_RDW = 5'd7, S_JSTART = 5'd8,
    S_P0 = 5'd9, S_P1 = 5'd10, S_MR = 5'd11, S_POS = 5'd12, S_MV = 5'd13,
    S_VDS = 5'd14, S_VDW = 5'd15, S_EMIT = 5'd16, S_REJ = 5'd17;

  logic [4:0]  state;
  logic [27:0] slot_map;
  logic [14:0] flip_mask;
  logic [2:0]  joints_in_use;

  logic [31:0] times [MaxPoints];
  logic [31:0] pos_mem [MaxPoints*Joints];
  logic [31:0] vel_mem [MaxPoints*Joints];
  logic [31:0] t_rd, p_rd, v_rd;
  logic [PtW-1:0]   t_addr;
  logic [ElemW-1:0] e_addr, w_addr;
  logic [PtW-1:0]   e_pt;

  logic        running;
  logic [6:0]  pts;
  logic [PtW-1:0] seg;
  logic [31:0] start_time, elapsed, t1, dt;
  logic        dt_ok, fin, neg;
  logic [24:0] ratio, mop;
  logic [2:0]  j;
  logic [31:0] p0, posv, velv;
  logic [32:0] mag;
  logic [57:0] prod;

  logic [32:0] dt33, num33, diff;
  logic [31:0] numc;
  logic [33:0] sdelta;
  logic [3:0]  cur_slot;
  logic        later;
  logic        out_free;
  logic        out_load;
  logic        in_acc;

  wti_div_ctl_t   dctl;
  logic [DivW-1:0] div_a, div_q;
  logic [DsrW-1:0] div_b;

  assign in_acc   = in_ch.valid & in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign out_free = !out_ch.valid || out_ch.ready;
  assign out_load = out_free && (state == S_EMIT || state == S_REJ);
  assign cur_slot = slot_map[4*j +: 4];

  // Config
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_map      <= 28'h0DCBA987;
      flip_mask     <= 15'h18A5;
      joints_in_use <= 3'd7;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOT_MAP: slot_map      <= cfg_data;
        REG_FLIP:     flip_mask     <= cfg_data[14:0];
        REG_JOINTS:   joints_in_use <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Table addressing
  always_comb begin
    unique case (state)
      S_LASTT: t_addr = PtW'(pts - 7'd1);
      S_WALK:  t_addr = seg + 1'b1;
      default: t_addr = seg;
    endcase
    if (state == S_P0) e_pt = seg + 1'b1;
    else if (fin)      e_pt = PtW'(pts - 7'd1);
    else               e_pt = seg;
    e_addr = ({3'b0, e_pt} << 3) - {3'b0, e_pt} + {6'b0, j};
    w_addr = ({3'b0, in_ch.data.point_index} << 3) - {3'b0, in_ch.data.point_index}
             + {6'b0, in_ch.data.joint};
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.data.command == CMD_LOAD && in_ch.data.joint < 3'(Joints)) begin
      times[in_ch.data.point_index] <= in_ch.data.time_us;
      pos_mem[w_addr] <= in_ch.data.position;
      vel_mem[w_addr] <= in_ch.data.velocity;
    end
    t_rd <= times[t_addr];
    p_rd <= pos_mem[e_addr];
    v_rd <= vel_mem[e_addr];
  end

  // Segment arithmetic helpers
  always_comb begin
    dt33   = {1'b0, t1} - {1'b0, t_rd};
    num33  = {1'b0, elapsed} - {1'b0, t_rd};
    if (num33[32])                 numc = '0;
    else if (num33[31:0] > dt33[31:0]) numc = dt33[31:0];
    else                           numc = num33[31:0];
    diff   = {p_rd[31], p_rd} - {p0[31], p0};
    sdelta = neg ? -{1'b0, prod[56:24]} : {1'b0, prod[56:24]};
    mop    = (state == S_MR) ? ratio : US_PER_SEC;
    div_a  = (state == S_T0C) ? {numc, 24'b0} : prod[DivW-1:0];
    // The ratio divide starts before dt is registered
    div_b  = (state == S_T0C) ? dt33[31:0] : dt;
    dctl.start = (state == S_T0C && !dt33[32] && dt33 != '0) || state == S_VDS;
  end

  // Is any later joint in use mapped to a slot
  always_comb begin
    later = 1'b0;
    for (int k = 0; k < Joints; k++) begin
      if (3'(k) > j && 3'(k) < joints_in_use && slot_map[4*k +: 4] != SLOT_NONE)
        later = 1'b1;
    end
  end

  wti_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dctl.start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (div_q),
    .busy     (dctl.busy),
    .done     (dctl.done)
  );

  function automatic logic [31:0] neg_sat(input logic [31:0] x);
    return (x == 32'h8000_0000) ? 32'h7FFF_FFFF : -x;
  endfunction

  always_ff @(posedge clk) begin
    if (state == S_MR || state == S_MV) prod <= mag * {33'b0, mop};
  end

  // Result word valid: set on a new word, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running       <= 1'b0;
      pts           <= '0;
      seg           <= '0;
      start_time    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_ch.data.command)
              CMD_LOAD: ;
              CMD_START: begin
                running <= 1'b0;
                seg     <= '0;
                if (in_ch.data.point_count == '0) begin
                  state <= S_REJ;
                end else begin
                  pts        <= (in_ch.data.point_count > 7'(MaxPoints)) ?
                                7'(MaxPoints) : in_ch.data.point_count;
                  start_time <= in_ch.data.time_us;
                  running    <= 1'b1;
                end
              end
              CMD_TICK: begin
                if (running && pts != '0) begin
                  elapsed <= in_ch.data.time_us - start_time;
                  state   <= S_LASTT;
                end
              end
              CMD_CANCEL: begin
                running <= 1'b0;
                seg     <= '0;
              end
            endcase
          end
        end
        S_LASTT: state <= S_LASTC;
        S_LASTC: begin
          j <= '0;
          if (elapsed >= t_rd) begin
            fin     <= 1'b1;
            running <= 1'b0;
            seg     <= '0;
            state   <= S_JSTART;
          end else begin
            fin <= 1'b0;
            if ({1'b0, seg} >= pts) seg <= '0;
            state <= S_WALK;
          end
        end
        S_WALK: state <= ({1'b0, seg} + 7'd1 < pts) ? S_WALKC : S_IDLE;
        S_WALKC: begin
          if (elapsed >= t_rd) begin
            seg   <= seg + 1'b1;
            state <= S_WALK;
          end else begin
            t1    <= t_rd;
            state <= S_T0;
          end
        end
        S_T0: state <= S_T0C;
        S_T0C: begin
          dt    <= dt33[31:0];
          dt_ok <= !dt33[32] && dt33 != '0;
          ratio <= '0;
          state <= (!dt33[32] && dt33 != '0) ? S_RDW : S_JSTART;
        end
        S_RDW: begin
          if (dctl.done) begin
            ratio <= div_q[24:0];
            state <= S_JSTART;
          end
        end
        S_JSTART: begin
          if (j >= joints_in_use)       state <= S_IDLE;
          else if (cur_slot == SLOT_NONE) j <= j + 1'b1;
          else                          state <= S_P0;
        end
        S_P0: begin
          p0 <= p_rd;
          if (fin) begin
            posv  <= p_rd;
            velv  <= v_rd;
            state <= S_EMIT;
          end else begin
            state <= S_P1;
          end
        end
        S_P1: begin
          neg   <= diff[32];
          mag   <= diff[32] ? -diff : diff;
          state <= S_MR;
        end
        S_MR: state <= S_POS;
        S_POS: begin
          posv <= 32'({p0[31], p0[31], p0} + sdelta);
          if (dt_ok) begin
            state <= S_MV;
          end else begin
            velv  <= '0;
            state <= S_EMIT;
          end
        end
        S_MV:  state <= S_VDS;
        S_VDS: state <= S_VDW;
        S_VDW: begin
          if (dctl.done) begin
            if (!neg) velv <= (div_q > DivW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_q[31:0];
            else      velv <= (div_q > DivW'(32'h8000_0000)) ? 32'h8000_0000 : -div_q[31:0];
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_ch.data.slot <= cur_slot;
            out_ch.data.joint_position <= flip_mask[cur_slot] ? neg_sat(posv) : posv;
            out_ch.data.joint_velocity <= flip_mask[cur_slot] ? neg_sat(velv) : velv;
            out_ch.data.status <= fin ? STAT_FIN : STAT_RUN;
            out_ch.data.last   <= !later;
            j     <= j + 1'b1;
            state <= S_JSTART;
          end
        end
        S_REJ: begin
          if (out_free) begin
            out_ch.data  <= '{slot: '0, joint_position: '0, joint_velocity: '0,
                              status: STAT_REJ, last: 1'b1};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/wti_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on wti_pkg.
module wti_div import wti_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DivW-1:0]   dividend,
  input  logic [DsrW-1:0]   divisor,
  output logic [DivW-1:0]   quotient,
  output logic              busy,
  output logic              done
);
  localparam int CntW = $clog2(DivW + 1);

  logic [CntW-1:0] cnt;
  logic [DsrW-1:0] rem;
  logic [DsrW-1:0] dsr;
  logic [DsrW:0]   trial;
  logic            fits;

  assign trial = {rem, quotient[DivW-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt  <= CntW'(DivW);
        busy <= 1'b1;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? DsrW'(trial - {1'b0, dsr}) : trial[DsrW-1:0];
      quotient <= {quotient[DivW-2:0], fits};
    end
  end
endmodule

@@ rtl/wti_checker.sv @@
// Port-level checks of the interpolator, bound to the top level.
// Depends on wti_pkg and assert_macros.svh.
`include "assert_macros.svh"
module wti_checker import wti_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_command,
  input logic [6:0] in_point_count,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic       out_last
);
  logic rej_acc;
  assign rej_acc = in_valid && in_ready && in_command == CMD_START && in_point_count == '0;

  `WTI_ASSERT(out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result word dropped")
  `WTI_ASSERT_ALWAYS(out_reset, clk, rst |=> !out_valid, "result word after reset")
  `WTI_ASSERT(rej_word, clk, rst, rej_acc && !out_valid |-> ##2 (out_valid && out_status == STAT_REJ && out_last), "missing reject word")
  `WTI_ASSERT(status_code, clk, rst, out_valid |-> out_status != 2'd3, "bad status code")
endmodule

bind waypoint_trajectory_interpolator wti_checker u_wti_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_command     (in_ch.data.command),
  .in_point_count (in_ch.data.point_count),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.data.status),
  .out_last       (out_ch.data.last)
);
